/* hdl/tensor_element_to_fp32_converter_unit_defines.svh */
// assertion macros for the tensor element converter checker
// no dependencies
`ifndef TENSOR_ELEMENT_TO_FP32_CONVERTER_UNIT_DEFINES_SVH
`define TENSOR_ELEMENT_TO_FP32_CONVERTER_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define TEC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tec check failed");

// next-cycle implication checked outside reset
`define TEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tec check failed");

`endif

/* hdl/tec_pkg.sv */
// shared types and constants for the tensor element converter
// no dependencies
package tec_pkg;
	typedef enum logic [2:0] {
		FUNC_F32 = 3'd0,
		FUNC_F64 = 3'd1,
		FUNC_I32 = 3'd2,
		FUNC_I8  = 3'd3,
		FUNC_F16 = 3'd4,
		FUNC_U8  = 3'd5
	} func_t;

	localparam logic [31:0] SGL_INF  = 32'h7f80_0000;
	localparam logic [31:0] SGL_QNAN = 32'h7fc0_0000;
	localparam logic [7:0]  HALF_TO_SGL_BIAS = 8'd112;

	// leading-one position of a 64-bit word
	function automatic logic [5:0] lead_one64(input logic [63:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 64; i++)
			if (v[i]) p = 6'(i);
		return p;
	endfunction
endpackage

/* hdl/tec_pack.sv */
// packs sign, significand and binary exponent into binary32
// depends on tec_pkg
module tec_pack (
	input  logic        sgn,
	input  logic [52:0] sig,
	input  logic signed [11:0] e2,
	output logic [31:0] res
);
	import tec_pkg::*;

	logic [5:0]  p;
	logic signed [13:0] fe;
	logic signed [13:0] sh_sub;
	logic [6:0]  sh;
	logic [116:0] ext;
	logic [116:0] shifted;
	logic [24:0] q;
	logic        guard;
	logic        sticky;
	logic [25:0] qr;
	logic        is_norm;
	logic [8:0]  fe_fin;

	always_comb begin
		p = lead_one64({11'd0, sig});
		fe = 14'(p) + 14'(e2) + 14'sd127;
		sh_sub = -(14'(e2) + 14'sd149);
		is_norm = (fe >= 14'sd1);
		// right shift amount so that bit 23 holds hidden bit (or 2^-149 unit)
		if (is_norm)
			sh = (p > 6'd23) ? 7'(p - 6'd23) : 7'd0;
		else if (sh_sub >= 14'sd64)
			sh = 7'd64;
		else if (sh_sub <= 14'sd0)
			sh = 7'd0;
		else
			sh = 7'(sh_sub);
		// sig below 2^53 with left shift only when small: place at bit 64
		ext = {sig, 64'd0};
		shifted = ext >> sh;
		// left shift cases: normalize small significands
		if (is_norm && p < 6'd23)
			shifted = ({sig, 64'd0} << (6'd23 - p));
		q = shifted[88:64];
		guard = shifted[63];
		sticky = |shifted[62:0];
		qr = {1'b0, q} + 26'((guard && (sticky || q[0])) ? 1 : 0);
		fe_fin = 9'(fe);
		res = {sgn, 31'd0};
		if (sig == '0) begin
			res = {sgn, 31'd0};
		end else if (is_norm) begin
			if (qr[24]) begin
				fe_fin = 9'(fe) + 9'd1;
				qr = qr >> 1;
			end
			if (fe >= 14'sd254 && (fe >= 14'sd255 || fe_fin == 9'd255))
				res = {sgn, SGL_INF[30:0]};
			else
				res = {sgn, fe_fin[7:0], qr[22:0]};
		end else if (sh_sub >= 14'sd64) begin
			res = {sgn, 31'd0};
		end else begin
			res = {sgn, 7'd0, qr[23:0]};
		end
	end
endmodule

/* hdl/tensor_element_to_fp32_converter_unit.sv */
// Converts one tensor element (f32, f64, i32, i8, f16, u8) to binary32 per request.
// One item per cycle while the output is not stalled; input register, rounding logic, result register.
// A result waits in the output register and the block keeps accepting while it is taken.
// depends on tec_pkg and tec_pack
module tensor_element_to_fp32_converter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [63:0] raw_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] single_bits
);
	import tec_pkg::*;

	logic        v_s1;
	logic [2:0]  func_s1;
	logic [63:0] raw_s1;
	logic        adv_s1;
	logic        sgn;
	logic [52:0] sig;
	logic signed [11:0] e2;
	logic [31:0] packed_w;
	logic [31:0] res;
	logic [10:0] dex;
	logic [31:0] mag32;
	logic [7:0]  mag8;
	logic [9:0]  hm;
	logic [3:0]  hp;

	// stage advance when output slot free or being drained
	assign adv_s1 = !out_valid || out_ready;
	assign in_ready = !v_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1 <= func;
			raw_s1  <= raw_bits;
		end
	end

	// operands for the shared packer
	always_comb begin
		dex   = raw_s1[62:52];
		mag32 = raw_s1[31] ? (~raw_s1[31:0] + 32'd1) : raw_s1[31:0];
		mag8  = raw_s1[7] ? (~raw_s1[7:0] + 8'd1) : raw_s1[7:0];
		sgn = 1'b0;
		sig = '0;
		e2  = '0;
		case (func_s1)
			FUNC_F64: begin
				sgn = raw_s1[63];
				if (dex == 11'd0) begin
					sig = {1'b0, raw_s1[51:0]};
					e2  = -12'sd1074;
				end else begin
					sig = {1'b1, raw_s1[51:0]};
					e2  = 12'(dex) - 12'sd1075;
				end
			end
			FUNC_I32: begin
				sgn = raw_s1[31];
				sig = {21'd0, mag32};
			end
			FUNC_I8: begin
				sgn = raw_s1[7];
				sig = {45'd0, mag8};
			end
			FUNC_U8: sig = {45'd0, raw_s1[7:0]};
			default: ;
		endcase
	end

	tec_pack u_pack (.sgn(sgn), .sig(sig), .e2(e2), .res(packed_w));

	// half subnormal normalize
	always_comb begin
		hp = '0;
		for (int i = 0; i < 10; i++)
			if (raw_s1[i]) hp = 4'(i);
		hm = 10'(raw_s1[9:0] << (4'd10 - hp));
	end

	// result select
	always_comb begin
		case (func_s1)
			FUNC_F32: res = raw_s1[31:0];
			FUNC_F64: begin
				if (dex == 11'h7ff)
					res = (raw_s1[51:0] != '0)
						? ({raw_s1[63], 31'd0} | SGL_QNAN | {10'd0, raw_s1[50:29]})
						: {raw_s1[63], SGL_INF[30:0]};
				else
					res = packed_w;
			end
			FUNC_I32, FUNC_I8, FUNC_U8: res = packed_w;
			FUNC_F16: begin
				if (raw_s1[14:10] == 5'd0) begin
					if (raw_s1[9:0] == '0)
						res = {raw_s1[15], 31'd0};
					else
						res = {raw_s1[15], 8'(HALF_TO_SGL_BIAS - 8'd9 + 8'(hp)),
							hm, 13'd0};
				end else if (raw_s1[14:10] == 5'h1f)
					res = {raw_s1[15], (raw_s1[9:0] != '0) ? SGL_QNAN[30:0] : SGL_INF[30:0]};
				else
					res = {raw_s1[15], 8'(raw_s1[14:10]) + HALF_TO_SGL_BIAS,
						raw_s1[9:0], 13'd0};
			end
			default: res = '0;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s1) begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && v_s1)
			single_bits <= res;
	end
endmodule

/* hdl/tec_checker.sv */
// port-level checker for the tensor element converter, bound to the top level
// depends on the defines header
`include "tensor_element_to_fp32_converter_unit_defines.svh"
module tec_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [2:0]  func,
	input logic [63:0] raw_bits,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] single_bits
);
	// stalled result holds
	`TEC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(single_bits))
	// free output slot means input is open
	`TEC_ASSERT_IMPL(a_ready_free, clk, arst_n, !out_valid, in_ready)
	// accepted request leads to a valid output once it has passed the input register
	`TEC_ASSERT_NEXT(a_no_drop, clk, arst_n, in_valid && in_ready, ##1 out_valid)
	// waiting request keeps its payload
	`TEC_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && !in_ready, in_valid && $stable(func) && $stable(raw_bits))
endmodule

bind tensor_element_to_fp32_converter_unit tec_checker u_tec_checker (.*);
